FILE: rtl/core/fuzzy_point_snapper_top_macros.svh
// assertion macros for the fuzzy point snapper
// needs signals clock and reset in the scope that uses them
`ifndef FUZZY_POINT_SNAPPER_TOP_MACROS_SVH
`define FUZZY_POINT_SNAPPER_TOP_MACROS_SVH

`ifndef SYNTH

// condition implies consequence in the same cycle
`define FPS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fps assertion failed");

// condition implies consequence in the next cycle
`define FPS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fps assertion failed");

`else

`define FPS_ASSERT_IMP(lbl, ante, cons)
`define FPS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/fps_pkg.sv
// shared types and constants of the fuzzy point snapper
// no dependencies
package fps_pkg;

   // table size and derived widths
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int COORD_W    = 24;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SCALE_W    = 16;
   localparam int SNAP_W     = 10;
   localparam int ENTRY_W    = 6;
   localparam int PROD_W     = DIFF_W + SCALE_W;
   localparam int SAT_W      = 22;
   localparam int SQ_W       = 2 * SAT_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int SNAP_SQ_W  = 2 * SNAP_W;
   localparam int FRAC_SQ_W  = 24;

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [SNAP_W-1:0] SNAP_RESET = SNAP_W'(20);
   localparam logic [SAT_W-1:0]  SAT_MAX    = {SAT_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_SNAP    = CSR_IDX_W'(2);

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } fps_state_type;

endpackage

FILE: rtl/core/fps_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module fps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/fuzzy_point_snapper_top.sv
// fuzzy point snapper: top level with scan sequencer and distance datapath
// depends on fps_pkg, fps_ram and fuzzy_point_snapper_top_macros.svh
//
// Usage: a query word (req_point_x, req_point_y) is taken at a rising edge
// with start high and busy low. The block then walks the point table in
// insertion order, one stored point per cycle through a shared distance
// datapath (ram read, difference, scale multiply, saturate and square,
// sum and compare). The first stored point within snap distance ends the
// walk. If none matches, the query is written into the next free slot,
// or overflow is flagged when the table is full.
// Result: the result word shows on the rsp_ ports, with rsp_valid high,
// for one cycle. busy falls in the cycle the result shows; no new query
// is taken while busy, so one query is through before another is taken.
// The receiver cannot stall: the result word is offered for one cycle only.
// Reset (synchronous, active high) empties the table and loads scale_x = 0,
// scale_y = 0 and snap_distance = 20. The csr_ port must be written only
// while the block is idle; the block itself does not enforce this. A write
// to an index beyond the list is ignored.
`include "fuzzy_point_snapper_top_macros.svh"

module fuzzy_point_snapper_top (
   input  logic                                clock,
   input  logic                                reset,
   // query channel
   input  logic                                start,
   output logic                                busy,
   input  logic signed [fps_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [fps_pkg::COORD_W-1:0]  req_point_y,
   // result channel
   output logic                                rsp_valid,
   output logic signed [fps_pkg::COORD_W-1:0]  rsp_snapped_x,
   output logic signed [fps_pkg::COORD_W-1:0]  rsp_snapped_y,
   output logic                                rsp_matched,
   output logic [fps_pkg::ENTRY_W-1:0]         rsp_entry_index,
   output logic                                rsp_overflow,
   // configuration port
   input  logic                                csr_we,
   input  logic [fps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fps_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import fps_pkg::*;

   // configuration registers
   logic [SCALE_W-1:0] scale_x_ff;
   logic [SCALE_W-1:0] scale_y_ff;
   logic [SNAP_W-1:0]  snap_ff;

   // sequencer
   fps_state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [CNT_W-1:0]   n_ff;
   logic [COORD_W-1:0] qx_ff, qy_ff;
   logic [SNAP_SQ_W-1:0] snap_sq_ff;
   logic accept;
   logic issue_en;
   logic scan_on;
   logic hit;
   logic done_miss;
   logic table_full;

   // ram
   logic [2*COORD_W-1:0] ram_rd_data;
   logic [2*COORD_W-1:0] ram_wr_data;

   // pipeline stage 0: ram data
   logic               v0_ff, v0_in;
   logic [IDX_W-1:0]   idx0_ff;
   logic [COORD_W-1:0] sx0, sy0;
   logic [DIFF_W-1:0]  dx, dy;
   logic [DIFF_W-1:0]  magx, magy;

   // stage 1: magnitudes
   logic               v1_ff, v1_in;
   logic [IDX_W-1:0]   idx1_ff;
   logic [COORD_W-1:0] sx1_ff, sy1_ff;
   logic [DIFF_W-1:0]  magx1_ff, magy1_ff;

   // stage 2: scaled products
   logic               v2_ff, v2_in;
   logic [IDX_W-1:0]   idx2_ff;
   logic [COORD_W-1:0] sx2_ff, sy2_ff;
   logic [PROD_W-1:0]  prodx2_ff, prody2_ff;
   logic [SAT_W-1:0]   satx, saty;

   // stage 3: squares
   logic               v3_ff, v3_in;
   logic [IDX_W-1:0]   idx3_ff;
   logic [COORD_W-1:0] sx3_ff, sy3_ff;
   logic [SQ_W-1:0]    sqx3_ff, sqy3_ff;
   logic [SUM_W-1:0]   dist_sq;
   logic [SUM_W-1:0]   bound;

   // result word
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_matched_ff, rsp_overflow_ff;
   logic [ENTRY_W-1:0] rsp_index_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= '0;
         scale_y_ff <= '0;
         snap_ff    <= SNAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE_X: scale_x_ff <= csr_wdata;
            CSR_SCALE_Y: scale_y_ff <= csr_wdata;
            CSR_SNAP:    snap_ff    <= csr_wdata[SNAP_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_SCAN;
         ST_SCAN: if (hit || done_miss) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy    = 1'b0;
      scan_on = 1'b0;
      unique case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_SCAN: begin
            busy    = 1'b1;
            scan_on = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   assign accept     = start && !busy;
   assign table_full = (n_ff == CNT_W'(TABLE_DEPTH));
   assign issue_en   = scan_on && (issue_ff != n_ff) && !hit;
   assign done_miss  = scan_on && (issue_ff == n_ff) &&
                       !v0_ff && !v1_ff && !v2_ff && !v3_ff;

   // issue counter and table fill count
   always_comb begin
      issue_in = issue_ff;
      if (accept) begin
         issue_in = '0;
      end else if (issue_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end
      count_in = count_ff;
      if (done_miss && !table_full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
      end
   end

   // query capture
   always_ff @(posedge clock) begin
      if (accept) begin
         qx_ff      <= req_point_x;
         qy_ff      <= req_point_y;
         n_ff       <= count_ff;
         snap_sq_ff <= SNAP_SQ_W'(snap_ff) * SNAP_SQ_W'(snap_ff);
      end
   end

   // point table, x in the upper half
   assign ram_wr_data = {qx_ff, qy_ff};

   fps_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (done_miss && !table_full),
      .wr_addr (n_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // stage valids, flushed on a hit or outside the scan
   assign v0_in = issue_en;
   assign v1_in = v0_ff && scan_on && !hit;
   assign v2_in = v1_ff && scan_on && !hit;
   assign v3_in = v2_ff && scan_on && !hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 0: signed differences and magnitudes
   assign sx0  = ram_rd_data[2*COORD_W-1:COORD_W];
   assign sy0  = ram_rd_data[COORD_W-1:0];
   assign dx   = {sx0[COORD_W-1], sx0} - {qx_ff[COORD_W-1], qx_ff};
   assign dy   = {sy0[COORD_W-1], sy0} - {qy_ff[COORD_W-1], qy_ff};
   assign magx = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
   assign magy = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;

   always_ff @(posedge clock) begin
      idx0_ff  <= issue_ff[IDX_W-1:0];
      idx1_ff  <= idx0_ff;
      sx1_ff   <= sx0;
      sy1_ff   <= sy0;
      magx1_ff <= magx;
      magy1_ff <= magy;
   end

   // stage 1: scale to q.12 pixels
   always_ff @(posedge clock) begin
      idx2_ff   <= idx1_ff;
      sx2_ff    <= sx1_ff;
      sy2_ff    <= sy1_ff;
      prodx2_ff <= PROD_W'(magx1_ff) * PROD_W'(scale_x_ff);
      prody2_ff <= PROD_W'(magy1_ff) * PROD_W'(scale_y_ff);
   end

   // stage 2: saturate just under 1024 pixels, then square
   assign satx = (prodx2_ff > PROD_W'(SAT_MAX)) ? SAT_MAX : prodx2_ff[SAT_W-1:0];
   assign saty = (prody2_ff > PROD_W'(SAT_MAX)) ? SAT_MAX : prody2_ff[SAT_W-1:0];

   always_ff @(posedge clock) begin
      idx3_ff <= idx2_ff;
      sx3_ff  <= sx2_ff;
      sy3_ff  <= sy2_ff;
      sqx3_ff <= SQ_W'(satx) * SQ_W'(satx);
      sqy3_ff <= SQ_W'(saty) * SQ_W'(saty);
   end

   // stage 3: squared distance against squared snap radius
   assign dist_sq = SUM_W'(sqx3_ff) + SUM_W'(sqy3_ff);
   assign bound   = {1'b0, snap_sq_ff, {FRAC_SQ_W{1'b0}}};
   assign hit     = v3_ff && scan_on && (dist_sq <= bound);

   // result word
   assign rsp_valid_in = hit || done_miss;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         rsp_x_ff        <= sx3_ff;
         rsp_y_ff        <= sy3_ff;
         rsp_matched_ff  <= 1'b1;
         rsp_index_ff    <= ENTRY_W'(idx3_ff);
         rsp_overflow_ff <= 1'b0;
      end else if (done_miss) begin
         rsp_x_ff        <= qx_ff;
         rsp_y_ff        <= qy_ff;
         rsp_matched_ff  <= 1'b0;
         rsp_index_ff    <= table_full ? '0 : ENTRY_W'(n_ff);
         rsp_overflow_ff <= table_full;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_snapped_x   = rsp_x_ff;
   assign rsp_snapped_y   = rsp_y_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_overflow    = rsp_overflow_ff;

   // checks
   `FPS_ASSERT_IMP(a_match_not_overflow, rsp_valid_ff, !(rsp_matched_ff && rsp_overflow_ff))
   `FPS_ASSERT_NXT(a_accept_no_early_rsp, accept, busy && !rsp_valid_ff)
   `FPS_ASSERT_IMP(a_rsp_when_idle, rsp_valid_ff, state_ff == ST_IDLE)
   `FPS_ASSERT_IMP(a_count_bounded, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))

endmodule

FILE: dv/testbench.sv
// self-checking testbench for fuzzy_point_snapper_top: directed corner words, then
// random query words over several register settings, checked against a local predictor
// depends on fps_pkg and the fuzzy_point_snapper_top rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fps_pkg::*;

   // index with no register behind it, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(3);
   localparam longint unsigned SCALED_SAT = 64'(SAT_MAX);
   localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W - 1));
   localparam int PHASES = 7;
   localparam int WORDS_PER_PHASE = 262;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;
   typedef struct packed {
      coord_type           x;
      coord_type           y;
      logic                matched;
      logic [ENTRY_W-1:0]  index;
      logic                overflow;
   } snap_word_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   coord_type             req_point_x = '0;
   coord_type             req_point_y = '0;
   logic                  rsp_valid;
   coord_type             rsp_snapped_x;
   coord_type             rsp_snapped_y;
   logic                  rsp_matched;
   logic [ENTRY_W-1:0]    rsp_entry_index;
   logic                  rsp_overflow;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   // local copy of the point table and registers
   coord_type          pts_x [TABLE_DEPTH];
   coord_type          pts_y [TABLE_DEPTH];
   int                 stored_n    = 0;
   logic [SCALE_W-1:0] scale_x_cfg = '0;
   logic [SCALE_W-1:0] scale_y_cfg = '0;
   logic [SNAP_W-1:0]  snap_cfg    = SNAP_RESET;

   point_type     query_q [$];
   snap_word_type pending_snaps [$];
   int            idle_pct    = 0;
   int            error_count = 0;

   fuzzy_point_snapper_top u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .rsp_valid       (rsp_valid),
      .rsp_snapped_x   (rsp_snapped_x),
      .rsp_snapped_y   (rsp_snapped_y),
      .rsp_matched     (rsp_matched),
      .rsp_entry_index (rsp_entry_index),
      .rsp_overflow    (rsp_overflow),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // saturated |a - b| * scale in q.12 pixels
   function automatic longint unsigned scaled_gap(coord_type a, coord_type b,
                                                  logic [SCALE_W-1:0] scale);
      longint d;
      longint unsigned mag;
      longint unsigned prod;
      d    = longint'(a) - longint'(b);
      mag  = (d < 0) ? longint'(-d) : longint'(d);
      prod = mag * longint'(scale);
      return (prod > SCALED_SAT) ? SCALED_SAT : prod;
   endfunction

   // first stored point within snap distance, else append or flag overflow
   function automatic snap_word_type snap_lookup(point_type q);
      snap_word_type   w;
      longint unsigned lim;
      longint unsigned bound;
      longint unsigned sx;
      longint unsigned sy;
      logic            hit;
      lim        = longint'(snap_cfg) << 12;
      bound      = lim * lim;
      hit        = 1'b0;
      w.x        = q.x;
      w.y        = q.y;
      w.matched  = 1'b0;
      w.index    = '0;
      w.overflow = 1'b0;
      for (int i = 0; i < stored_n && !hit; i++) begin
         sx = scaled_gap(pts_x[i], q.x, scale_x_cfg);
         sy = scaled_gap(pts_y[i], q.y, scale_y_cfg);
         if (sx * sx + sy * sy <= bound) begin
            hit       = 1'b1;
            w.x       = pts_x[i];
            w.y       = pts_y[i];
            w.matched = 1'b1;
            w.index   = ENTRY_W'(i);
         end
      end
      if (!hit) begin
         if (stored_n < TABLE_DEPTH) begin
            pts_x[stored_n] = q.x;
            pts_y[stored_n] = q.y;
            w.index         = ENTRY_W'(stored_n);
            stored_n++;
         end else begin
            w.overflow = 1'b1;
         end
      end
      return w;
   endfunction

   // map distance that renders as about one snap radius on an axis
   function automatic longint axis_reach(logic [SCALE_W-1:0] scale);
      longint r;
      r = (scale == 0) ? 64 : (longint'(snap_cfg) * 4096) / longint'(scale) + 1;
      return (r > (longint'(1) << 22)) ? (longint'(1) << 22) : r;
   endfunction

   function automatic coord_type clamp_coord(longint v);
      if (v > COORD_MAX) return coord_type'(COORD_MAX);
      if (v < COORD_MIN) return coord_type'(COORD_MIN);
      return coord_type'(v);
   endfunction

   // query around a stored point: exact copies, hits and near misses
   function automatic point_type near_point();
      point_type p;
      int        k;
      longint    rx;
      longint    ry;
      k  = $urandom_range(stored_n - 1);
      rx = axis_reach(scale_x_cfg);
      ry = axis_reach(scale_y_cfg);
      if ($urandom_range(5) == 0) begin
         p.x = pts_x[k];
         p.y = pts_y[k];
      end else begin
         p.x = clamp_coord(longint'(pts_x[k]) + longint'($urandom_range(4 * rx)) - 2 * rx);
         p.y = clamp_coord(longint'(pts_y[k]) + longint'($urandom_range(4 * ry)) - 2 * ry);
      end
      return p;
   endfunction

   // anywhere on the map, with the range ends, zero and -1 now and then
   function automatic point_type far_point();
      point_type p;
      coord_type ends [4];
      ends = '{coord_type'(COORD_MIN), coord_type'(COORD_MAX), coord_type'(0),
               coord_type'(-1)};
      p.x  = ($urandom_range(11) == 0) ? ends[$urandom_range(3)] : coord_type'($urandom);
      p.y  = ($urandom_range(11) == 0) ? ends[$urandom_range(3)] : coord_type'($urandom);
      return p;
   endfunction

   task automatic push_point(point_type p);
      while (query_q.size() >= 2) @(negedge clock);
      query_q.insert(query_q.size(), p);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SCALE_X: scale_x_cfg = val[SCALE_W-1:0];
         CSR_SCALE_Y: scale_y_cfg = val[SCALE_W-1:0];
         CSR_SNAP:    snap_cfg    = val[SNAP_W-1:0];
         default:     ;
      endcase
   endtask

   task automatic set_config(int unsigned sx, int unsigned sy, int unsigned sd);
      write_csr(CSR_SCALE_X, CSR_DATA_W'(sx));
      write_csr(CSR_SCALE_Y, CSR_DATA_W'(sy));
      write_csr(CSR_SNAP, CSR_DATA_W'(sd));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every word is accepted and answered, then let the block settle
   task automatic drain();
      do @(negedge clock);
      while (query_q.size() != 0 || start || pending_snaps.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // driver: hold a query word until accepted, idle at random between words
   always @(posedge clock) begin
      point_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pending_snaps.insert(pending_snaps.size(),
                                 snap_lookup('{req_point_x, req_point_y}));
         end
         if (!(start && busy)) begin
            if (query_q.size() != 0 &&
                (idle_pct == 0 || (!busy && $urandom_range(99) >= idle_pct))) begin
               nxt = query_q.pop_front();
               start       <= 1'b1;
               req_point_x <= nxt.x;
               req_point_y <= nxt.y;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      snap_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_snaps.size() == 0) begin
            $error("result word with none pending: x=%0h y=%0h", rsp_snapped_x, rsp_snapped_y);
            error_count++;
         end else begin
            want = pending_snaps.pop_front();
            check_field("snapped_x", want.x, rsp_snapped_x);
            check_field("snapped_y", want.y, rsp_snapped_y);
            check_field("matched", COORD_W'(want.matched), COORD_W'(rsp_matched));
            check_field("entry_index", COORD_W'(want.index), COORD_W'(rsp_entry_index));
            check_field("overflow", COORD_W'(want.overflow), COORD_W'(rsp_overflow));
         end
      end
   end

   // stimulus sequence
   initial begin
      int unsigned cfg_sx [PHASES];
      int unsigned cfg_sy [PHASES];
      int unsigned cfg_sd [PHASES];
      int          cfg_idle [PHASES];
      cfg_sx   = '{4096, 65535, 1, 8192, 0, 0, 300};
      cfg_sy   = '{4096, 1, 1, 2048, 0, 0, 65535};
      cfg_sd   = '{20, 1023, 0, 5, 1023, 0, 64};
      cfg_idle = '{0, 72, 0, 16, 72, 0, 72};
      // one phase with random registers, junk in the unused snap bits
      cfg_sx[5] = $urandom_range(65535);
      cfg_sy[5] = $urandom_range(65535);
      cfg_sd[5] = ($urandom_range(63) << SNAP_W) | $urandom_range(1023);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero scale merges everything into the first point
      push_point('{coord_type'(COORD_MIN), coord_type'(COORD_MAX)});
      push_point('{coord_type'(COORD_MAX), coord_type'(COORD_MIN)});
      drain();

      // largest scale and radius: saturation and the match boundary
      set_config(65535, 65535, 1023);
      write_csr(CSR_UNUSED, '1);
      @(posedge clock);
      csr_we <= 1'b0;
      push_point('{coord_type'(COORD_MAX), coord_type'(COORD_MIN)});
      push_point('{coord_type'(0), coord_type'(0)});
      push_point('{coord_type'(1), coord_type'(-1)});
      push_point('{coord_type'(-1000), coord_type'(0)});
      push_point('{coord_type'(63), coord_type'(0)});
      push_point('{coord_type'(64), coord_type'(0)});
      drain();

      // unit scale: distance exactly at the radius and just past it
      set_config(4096, 4096, 20);
      push_point('{coord_type'(20), coord_type'(0)});
      push_point('{coord_type'(12), coord_type'(-16)});
      push_point('{coord_type'(21), coord_type'(0)});
      push_point('{coord_type'(COORD_MIN), coord_type'(COORD_MIN)});
      push_point('{coord_type'(COORD_MAX), coord_type'(COORD_MAX)});
      drain();

      // zero radius: only an exact copy merges
      set_config(4096, 4096, 0);
      push_point('{coord_type'(0), coord_type'(0)});
      push_point('{coord_type'(0), coord_type'(1)});
      drain();

      // random phases, the table fills early and then overflows
      for (int p = 0; p < PHASES; p++) begin
         set_config(cfg_sx[p], cfg_sy[p], cfg_sd[p]);
         idle_pct = cfg_idle[p];
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (stored_n != 0 && $urandom_range(99) < 60) push_point(near_point());
            else push_point(far_point());
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("fuzzy_point_snapper_top regression: pass");
      end else begin
         $display("fuzzy_point_snapper_top regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("fuzzy_point_snapper_top regression: fail");
      $finish;
   end

endmodule
